/* rtl/rme_pkg.sv */
// ----------------------------------------------------------------------------
// rme_pkg
// Shared widths, types and helper functions for the rotation matrix to
// Euler angles pipeline.
// ----------------------------------------------------------------------------
package rme_pkg;

	localparam int DATA_WIDTH    = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int MAX_STAGES    = 32;
	localparam int STEPS         = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
	localparam int GUARD_BITS    = 12;
	localparam int VEC_W         = DATA_WIDTH + GUARD_BITS + 4;
	localparam int ANG_W         = 32;
	localparam int ANGLE_W       = 16;
	localparam int STEP_IDX_W    = $clog2(MAX_STAGES);
	localparam int GAIN_W        = 16;
	localparam int GAIN_SHIFT    = 16;
	localparam int PROD_W        = VEC_W - 1 + GAIN_W;
	localparam int PIPE_DEPTH    = 2 * STEPS + 4;

	localparam logic [GAIN_W-1:0] INV_GAIN   = GAIN_W'(39797);
	localparam logic [ANG_W-1:0]  ANGLE_PI   = {1'b1, {(ANG_W-1){1'b0}}};
	localparam logic [ANG_W-1:0]  ROUND_HALF = ANG_W'(32768);

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic [ANG_W-1:0]        z;
		logic                    zero;
	} vec_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] roll;
		logic signed [ANGLE_W-1:0] yaw;
	} side_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] roll;
		logic signed [ANGLE_W-1:0] pitch;
		logic signed [ANGLE_W-1:0] yaw;
	} angles_t;

	// atan(2^-i), 2^31 = pi
	function automatic logic [ANG_W-1:0] atan_step(input logic [STEP_IDX_W-1:0] i);
		logic [ANG_W-1:0] a;
		case (i)
			5'd0:    a = 32'd536870912;
			5'd1:    a = 32'd316933406;
			5'd2:    a = 32'd167458907;
			5'd3:    a = 32'd85004756;
			5'd4:    a = 32'd42667331;
			5'd5:    a = 32'd21354465;
			5'd6:    a = 32'd10679838;
			5'd7:    a = 32'd5340245;
			5'd8:    a = 32'd2670163;
			5'd9:    a = 32'd1335087;
			5'd10:   a = 32'd667544;
			5'd11:   a = 32'd333772;
			5'd12:   a = 32'd166886;
			5'd13:   a = 32'd83443;
			5'd14:   a = 32'd41722;
			5'd15:   a = 32'd20861;
			5'd16:   a = 32'd10430;
			5'd17:   a = 32'd5215;
			5'd18:   a = 32'd2608;
			5'd19:   a = 32'd1304;
			5'd20:   a = 32'd652;
			5'd21:   a = 32'd326;
			5'd22:   a = 32'd163;
			5'd23:   a = 32'd81;
			5'd24:   a = 32'd41;
			5'd25:   a = 32'd20;
			5'd26:   a = 32'd10;
			5'd27:   a = 32'd5;
			5'd28:   a = 32'd3;
			5'd29:   a = 32'd1;
			5'd30:   a = 32'd1;
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic logic signed [VEC_W-1:0] scale_in(input logic signed [DATA_WIDTH-1:0] v);
		logic signed [VEC_W-1:0] t;
		t = VEC_W'(v);
		return t <<< GUARD_BITS;
	endfunction

	// move the vector into the right half plane
	function automatic vec_t prerotate(input logic signed [VEC_W-1:0] x,
			input logic signed [VEC_W-1:0] y);
		vec_t v;
		v.zero = (x == '0) && (y == '0);
		if (x[VEC_W-1]) begin
			v.x = -x;
			v.y = -y;
			v.z = ANGLE_PI;
		end else begin
			v.x = x;
			v.y = y;
			v.z = '0;
		end
		return v;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] round_angle(input vec_t v);
		logic [ANG_W-1:0] s;
		s = v.z + ROUND_HALF;
		return v.zero ? '0 : $signed(s[ANG_W-1:ANG_W-ANGLE_W]);
	endfunction

endpackage

/* rtl/rme_stream_if.sv */
// ----------------------------------------------------------------------------
// rme_stream_if
// Valid/ready channels for matrix items and angle items.
// ----------------------------------------------------------------------------
interface rme_in_if import rme_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] rot_00;
	logic signed [DATA_WIDTH-1:0] rot_10;
	logic signed [DATA_WIDTH-1:0] rot_20;
	logic signed [DATA_WIDTH-1:0] rot_21;
	logic signed [DATA_WIDTH-1:0] rot_22;

	modport source (output valid, rot_00, rot_10, rot_20, rot_21, rot_22, input ready);
	modport sink (input valid, rot_00, rot_10, rot_20, rot_21, rot_22, output ready);
endinterface

interface rme_out_if import rme_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] roll_angle;
	logic signed [ANGLE_W-1:0] pitch_angle;
	logic signed [ANGLE_W-1:0] yaw_angle;

	modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

/* rtl/rme_cordic_step.sv */
// ----------------------------------------------------------------------------
// rme_cordic_step
// One registered vectoring CORDIC micro-rotation.
// ----------------------------------------------------------------------------
module rme_cordic_step import rme_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [STEP_IDX_W-1:0] idx,
	input  vec_t                  d,
	output vec_t                  q
);

	logic signed [VEC_W-1:0] dx;
	logic signed [VEC_W-1:0] dy;
	logic [ANG_W-1:0]        a;
	logic                    y_pos;
	vec_t                    nxt;

	always_comb begin
		dx    = d.y >>> idx;
		dy    = d.x >>> idx;
		a     = atan_step(idx);
		y_pos = !d.y[VEC_W-1] && (d.y != '0);
		nxt.zero = d.zero;
		if (y_pos) begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + a;
		end else begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

/* rtl/rme_ctrl.sv */
// ----------------------------------------------------------------------------
// rme_ctrl
// Valid bits and per-stage load enables; empty stages absorb stalls.
// ----------------------------------------------------------------------------
module rme_ctrl import rme_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIPE_DEPTH-1:0] en
);

	logic [PIPE_DEPTH-1:0] valid_q;

	for (genvar k = 0; k < PIPE_DEPTH; k++) begin : g_en
		assign en[k] = out_ready | ~(&valid_q[PIPE_DEPTH-1:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < PIPE_DEPTH; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_q[PIPE_DEPTH-1];

`ifndef SYNTHESIS
	a_ready_low_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&valid_q))
		else $error("input blocked while pipeline has a free stage");

	a_item_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(valid_q) == $countones($past(valid_q))
			+ ($past(in_valid && in_ready) ? 1 : 0)
			- ($past(out_valid && out_ready) ? 1 : 0)))
		else $error("item lost or duplicated in pipeline");

	a_drain_moves_all: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> (&en))
		else $error("stage held while output is taken");
`endif

endmodule

/* rtl/rotation_matrix_to_euler_angles_unit.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_unit
// Roll, pitch and yaw from a rotation matrix by pipelined vectoring CORDIC.
//
//   channel  dir  fields                                    handshake
//   matrix   in   rot_00 rot_10 rot_20 rot_21 rot_22        valid/ready
//   angles   out  roll_angle pitch_angle yaw_angle          valid/ready
//
// One item per cycle sustained while the output is ready; the data passes
// through the roll CORDIC, the gain multiplier and the pitch CORDIC in series.
// Reset clears only the stage valid bits.
// A stalled output holds the last stage; earlier stages keep moving until
// every stage is full, then the input is held off.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles_unit import rme_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	rme_in_if.sink    matrix,
	rme_out_if.source angles
);

	localparam int MUL_STG   = STEPS + 1;
	localparam int PITCH_STG = STEPS + 2;
	localparam int OUT_STG   = 2 * STEPS + 3;

	logic [PIPE_DEPTH-1:0] en;

	vec_t roll_p0_s;
	vec_t yaw_p0_s;
	vec_t pitch_p0_s;
	vec_t roll_vec [0:STEPS];
	vec_t yaw_vec [0:STEPS];
	vec_t pitch_vec [0:STEPS];

	logic signed [DATA_WIDTH-1:0] r20_s [0:STEPS];
	logic signed [DATA_WIDTH-1:0] r20_mul_s;
	logic signed [VEC_W-1:0]      hyp_mul_s;
	side_t                        side_mul_s;
	side_t                        side_s [0:STEPS];
	angles_t                      out_s;

	logic [VEC_W-2:0]  mag;
	logic [PROD_W-1:0] prod;

	rme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (matrix.valid),
		.in_ready  (matrix.ready),
		.out_valid (angles.valid),
		.out_ready (angles.ready),
		.en        (en)
	);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			roll_p0_s <= prerotate(scale_in(matrix.rot_22), scale_in(matrix.rot_21));
			yaw_p0_s  <= prerotate(scale_in(matrix.rot_00), scale_in(matrix.rot_10));
			r20_s[0]  <= matrix.rot_20;
		end
		for (int k = 1; k <= STEPS; k++) begin
			if (en[k]) begin
				r20_s[k] <= r20_s[k-1];
			end
		end
	end

	assign roll_vec[0] = roll_p0_s;
	assign yaw_vec[0]  = yaw_p0_s;

	for (genvar i = 0; i < STEPS; i++) begin : g_first
		rme_cordic_step u_roll (
			.clk (clk),
			.en  (en[i+1]),
			.idx (STEP_IDX_W'(i)),
			.d   (roll_vec[i]),
			.q   (roll_vec[i+1])
		);
		rme_cordic_step u_yaw (
			.clk (clk),
			.en  (en[i+1]),
			.idx (STEP_IDX_W'(i)),
			.d   (yaw_vec[i]),
			.q   (yaw_vec[i+1])
		);
	end

	// magnitude times 1/K
	always_comb begin
		mag  = roll_vec[STEPS].x[VEC_W-1] ? '0 : roll_vec[STEPS].x[VEC_W-2:0];
		prod = PROD_W'(mag) * PROD_W'(INV_GAIN);
	end

	always_ff @(posedge clk) begin
		if (en[MUL_STG]) begin
			hyp_mul_s       <= $signed({1'b0, prod[VEC_W-2+GAIN_SHIFT:GAIN_SHIFT]});
			r20_mul_s       <= r20_s[STEPS];
			side_mul_s.roll <= round_angle(roll_vec[STEPS]);
			side_mul_s.yaw  <= round_angle(yaw_vec[STEPS]);
		end
		if (en[PITCH_STG]) begin
			pitch_p0_s <= prerotate(hyp_mul_s, -scale_in(r20_mul_s));
			side_s[0]  <= side_mul_s;
		end
		for (int j = 1; j <= STEPS; j++) begin
			if (en[PITCH_STG+j]) begin
				side_s[j] <= side_s[j-1];
			end
		end
		if (en[OUT_STG]) begin
			out_s.roll  <= side_s[STEPS].roll;
			out_s.yaw   <= side_s[STEPS].yaw;
			out_s.pitch <= round_angle(pitch_vec[STEPS]);
		end
	end

	assign pitch_vec[0] = pitch_p0_s;

	for (genvar i = 0; i < STEPS; i++) begin : g_pitch
		rme_cordic_step u_pitch (
			.clk (clk),
			.en  (en[PITCH_STG+i+1]),
			.idx (STEP_IDX_W'(i)),
			.d   (pitch_vec[i]),
			.q   (pitch_vec[i+1])
		);
	end

	assign angles.roll_angle  = out_s.roll;
	assign angles.pitch_angle = out_s.pitch;
	assign angles.yaw_angle   = out_s.yaw;

endmodule

/* sim/rotation_matrix_to_euler_angles_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_unit_tb
// Streams matrix items into the angle extractor and checks the roll, pitch
// and yaw of every result against a bit-exact CORDIC predictor.
// The stimulus covers corner values, raw random bit patterns, true rotations,
// near gimbal lock, a full drain and a back-to-back phase.
// Random stalls are applied on both channels, except in the back-to-back phase.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles_unit_tb import rme_pkg::*; ();

	localparam int     CYCLE_LIMIT     = 300000;
	localparam longint HALF_TURN       = 64'sd2147483648;
	localparam longint INV_GAIN_Q16    = 64'sd39797;
	localparam real    PI              = 3.14159265358979;
	localparam int     SETTLE_CYCLES   = PIPE_DEPTH + 16;

	localparam longint ATAN_TABLE [MAX_STAGES] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] r00;
		logic signed [DATA_WIDTH-1:0] r10;
		logic signed [DATA_WIDTH-1:0] r20;
		logic signed [DATA_WIDTH-1:0] r21;
		logic signed [DATA_WIDTH-1:0] r22;
	} matrix_item_t;

	logic clk;
	logic arst_n;

	rme_in_if  matrix ();
	rme_out_if angles ();

	rotation_matrix_to_euler_angles_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.matrix (matrix),
		.angles (angles)
	);

	angles_t expected_angles[$];
	int      error_count = 0;
	int      cycle_count = 0;
	bit      idle_enable = 1'b1;
	int      stall_left  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint cordic_vector(input longint yv, input longint xv,
			output longint mag);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		int     i;
		x = xv;
		y = yv;
		z = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			return 0;
		end
		if (x < 0) begin
			z = (y >= 0) ? HALF_TURN : -HALF_TURN;
			x = -x;
			y = -y;
		end
		for (i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TABLE[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TABLE[i];
			end
		end
		mag = x;
		return z;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] binary_angle(input longint z);
		longint t;
		t = (z + 32768) >>> 16;
		return t[ANGLE_W-1:0];
	endfunction

	function automatic angles_t predict_angles(input matrix_item_t m);
		longint  r00;
		longint  r10;
		longint  r20;
		longint  r21;
		longint  r22;
		longint  mag;
		longint  discard;
		longint  hyp;
		angles_t a;
		r00 = longint'(m.r00) * (64'sd1 << GUARD_BITS);
		r10 = longint'(m.r10) * (64'sd1 << GUARD_BITS);
		r20 = longint'(m.r20) * (64'sd1 << GUARD_BITS);
		r21 = longint'(m.r21) * (64'sd1 << GUARD_BITS);
		r22 = longint'(m.r22) * (64'sd1 << GUARD_BITS);
		a.roll = binary_angle(cordic_vector(r21, r22, mag));
		if (mag < 0)
			mag = 0;
		hyp = (mag * INV_GAIN_Q16) >>> GAIN_SHIFT;
		a.pitch = binary_angle(cordic_vector(-r20, hyp, discard));
		a.yaw = binary_angle(cordic_vector(r10, r00, discard));
		return a;
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] to_q14(input real v);
		real s;
		s = v * 16384.0;
		if (s > 32767.0)
			s = 32767.0;
		if (s < -32768.0)
			s = -32768.0;
		return DATA_WIDTH'($rtoi(s));
	endfunction

	function automatic real random_angle(input real span);
		return (real'($urandom_range(0, 65535)) - 32768.0) * span / 32768.0;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] random_entry();
		return DATA_WIDTH'($urandom);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	task automatic send_matrix(input logic [DATA_WIDTH-1:0] r00, input logic [DATA_WIDTH-1:0] r10,
			input logic [DATA_WIDTH-1:0] r20, input logic [DATA_WIDTH-1:0] r21,
			input logic [DATA_WIDTH-1:0] r22);
		matrix_item_t m;
		m = '{r00, r10, r20, r21, r22};
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			matrix.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		matrix.valid  <= 1'b1;
		matrix.rot_00 <= m.r00;
		matrix.rot_10 <= m.r10;
		matrix.rot_20 <= m.r20;
		matrix.rot_21 <= m.r21;
		matrix.rot_22 <= m.r22;
		do
			@(posedge clk);
		while (!matrix.ready);
		expected_angles = {expected_angles, predict_angles(m)};
	endtask

	task automatic send_rotation(input real roll, input real pitch, input real yaw);
		real cp;
		cp = $cos(pitch);
		send_matrix(to_q14($cos(yaw) * cp), to_q14($sin(yaw) * cp), to_q14(-$sin(pitch)),
			to_q14(cp * $sin(roll)), to_q14(cp * $cos(roll)));
	endtask

	task automatic wait_results_drained();
		matrix.valid <= 1'b0;
		while (expected_angles.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_corner_values();
		send_matrix(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_matrix(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
		send_matrix(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
		send_matrix(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
		// negative x on the real axis: angle of pi wraps
		send_matrix(-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384);
		send_matrix(-16'sd16384, -16'sd1, 16'sd0, -16'sd1, -16'sd16384);
		send_matrix(-16'sd16384, 16'sd1, 16'sd0, 16'sd1, -16'sd16384);
		// gimbal lock, pitch of plus and minus a quarter turn
		send_matrix(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0);
		send_matrix(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0);
		send_matrix(16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0);
		send_matrix(16'sd0, -16'sd16384, 16'sd0, -16'sd16384, 16'sd0);
		send_matrix(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
		send_matrix(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
		send_matrix(16'sd1, 16'sd0, -16'sd32768, 16'sd32767, 16'sd32767);
		send_matrix(-16'sd1, 16'sd0, 16'sd32767, -16'sd32768, -16'sd32768);
		send_matrix(16'sd0, 16'sd1, 16'sd0, -16'sd32768, 16'sd0);
		send_matrix(16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
		send_matrix(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
		send_matrix(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
		send_matrix(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
	endtask

	task automatic test_raw_bit_patterns(input int count);
		repeat (count)
			send_matrix(random_entry(), random_entry(), random_entry(), random_entry(),
				random_entry());
	endtask

	task automatic test_rotations(input int count);
		repeat (count)
			send_rotation(random_angle(PI), random_angle(PI / 2.0), random_angle(PI));
	endtask

	task automatic test_near_gimbal_lock(input int count);
		real p;
		repeat (count) begin
			p = PI / 2.0 - real'($urandom_range(0, 200)) / 16384.0;
			if ($urandom_range(0, 1) == 1)
				p = -p;
			send_rotation(random_angle(PI), p, random_angle(PI));
		end
	endtask

	task automatic test_drain_and_resume();
		wait_results_drained();
		test_rotations(20);
	endtask

	task automatic test_back_to_back(input int count);
		idle_enable = 1'b0;
		repeat (count) begin
			if ($urandom_range(0, 1) == 1)
				send_matrix(random_entry(), random_entry(), random_entry(), random_entry(),
					random_entry());
			else
				send_rotation(random_angle(PI), random_angle(PI / 2.0), random_angle(PI));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			angles.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			angles.ready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			angles.ready <= 1'b0;
		end else begin
			angles.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		angles_t want;
		if (arst_n && angles.valid && angles.ready) begin
			if (expected_angles.size() == 0) begin
				report_mismatch("unexpected item roll", angles.roll_angle, 0);
			end else begin
				want = expected_angles.pop_front();
				if (angles.roll_angle !== want.roll)
					report_mismatch("roll_angle", angles.roll_angle, want.roll);
				if (angles.pitch_angle !== want.pitch)
					report_mismatch("pitch_angle", angles.pitch_angle, want.pitch);
				if (angles.yaw_angle !== want.yaw)
					report_mismatch("yaw_angle", angles.yaw_angle, want.yaw);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		matrix.valid  = 1'b0;
		matrix.rot_00 = '0;
		matrix.rot_10 = '0;
		matrix.rot_20 = '0;
		matrix.rot_21 = '0;
		matrix.rot_22 = '0;
		angles.ready  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_values();
		test_raw_bit_patterns(280);
		test_rotations(300);
		test_near_gimbal_lock(60);
		test_drain_and_resume();
		test_back_to_back(220);

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
rtl/rme_pkg.sv
rtl/rme_stream_if.sv
rtl/rme_cordic_step.sv
rtl/rme_ctrl.sv
rtl/rotation_matrix_to_euler_angles_unit.sv
sim/rotation_matrix_to_euler_angles_unit_tb.sv
